### rtl/core/flash_write_page_erase_splitter_assert.svh
// Assertion macros used by the flash write splitter top level.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FLASH_WRITE_PAGE_ERASE_SPLITTER_ASSERT_SVH
`define FLASH_WRITE_PAGE_ERASE_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FWPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwps assertion failed");

// Next-cycle implication, checked out of reset.
`define FWPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwps assertion failed");

`endif

### rtl/core/fwps_pkg.sv
// Types, constants and codes of the flash write splitter.
// No dependencies; used by every module of the block.
package fwps_pkg;

    localparam int ADDR_W       = 24;
    localparam int LEN_W        = 16;
    localparam int COUNT_W      = 9;
    localparam int OP_W         = 2;
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_W       = $clog2(PAGE_BYTES);
    localparam int SECTOR_W     = $clog2(SECTOR_BYTES);

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ERASE   = 2'd0,
        OP_PROGRAM = 2'd1,
        OP_IDLE    = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  remaining;
        logic [LEN_W-1:0]  offset;
        logic              erased;
    } state_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic [LEN_W-1:0]   offset;
        logic               last;
    } result_t;

endpackage

### rtl/core/fwps_step.sv
// Next-operation logic of the flash write splitter: state and one input
// transaction in, next state and the result out. Depends on fwps_pkg.
module fwps_step (
    input  logic                           func,
    input  logic [fwps_pkg::ADDR_W-1:0]    start_address,
    input  logic [fwps_pkg::LEN_W-1:0]     byte_length,
    input  fwps_pkg::state_t               state,
    output fwps_pkg::state_t               state_next,
    output fwps_pkg::result_t              result,
    output logic                           has_result
);
    import fwps_pkg::*;

    logic [PAGE_W-1:0]  page_off;
    logic [LEN_W-1:0]   page_room;
    logic [LEN_W-1:0]   count;
    logic               sector_start;

    assign page_off     = state.addr[PAGE_W-1:0];
    assign page_room    = LEN_W'(PAGE_BYTES) - LEN_W'(page_off);
    assign count        = (state.remaining < page_room) ? state.remaining : page_room;
    assign sector_start = (state.addr[SECTOR_W-1:0] == '0);

    always_comb
    begin
        state_next    = state;
        result        = '0;
        result.kind   = OP_IDLE;
        has_result    = 1'b0;
        priority if (func == FUNC_LOAD)
        begin
            state_next.addr      = start_address;
            state_next.remaining = byte_length;
            state_next.offset    = '0;
            state_next.erased    = 1'b0;
        end
        else if (state.remaining == '0)
        begin
            has_result = 1'b1;
        end
        else if (sector_start && !state.erased)
        begin
            // erase the sector before its first program
            has_result        = 1'b1;
            result.kind       = OP_ERASE;
            result.addr       = state.addr;
            state_next.erased = 1'b1;
        end
        else
        begin
            has_result           = 1'b1;
            result.kind          = OP_PROGRAM;
            result.addr          = state.addr;
            result.count         = count[COUNT_W-1:0];
            result.offset        = state.offset;
            result.last          = (count == state.remaining);
            state_next.addr      = state.addr + ADDR_W'(count);
            state_next.remaining = state.remaining - count;
            state_next.offset    = state.offset + count;
            state_next.erased    = 1'b0;
        end
    end

endmodule

### rtl/core/fwps_out_reg.sv
// Result register of the flash write splitter: holds one result until the
// receiver takes it, and frees itself in the same cycle. Depends on fwps_pkg.
module fwps_out_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  fwps_pkg::result_t              result,
    output logic                           free,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fwps_pkg::OP_W-1:0]      op_kind,
    output logic [fwps_pkg::ADDR_W-1:0]    flash_address,
    output logic [fwps_pkg::COUNT_W-1:0]   byte_count,
    output logic [fwps_pkg::LEN_W-1:0]     buffer_offset,
    output logic                           last
);
    import fwps_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // a slot is free when empty or being drained this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid     = valid_reg;
    assign op_kind       = data_reg.kind;
    assign flash_address = data_reg.addr;
    assign byte_count    = data_reg.count;
    assign buffer_offset = data_reg.offset;
    assign last          = data_reg.last;

endmodule

### rtl/core/flash_write_page_erase_splitter.sv
// Flash write splitter top level: request state registers, step logic and
// result register. Depends on fwps_pkg, fwps_step, fwps_out_reg and the
// assertion header.
//
// Usage: the input channel (in_valid/in_ready) carries func, start_address
// and byte_length. A load transaction (func 0) latches a new write request
// and replaces any pending one; it produces no result. Each advance
// transaction (func 1) produces exactly one result on the output channel
// (out_valid/out_ready): a sector erase, a page program with its byte count
// and buffer offset, or idle once the request is done.
// Latency: out_valid rises in the cycle after an accepted advance. Throughput:
// one transaction per cycle unless stalled; the step logic is a page mask,
// four compares and the address/length adders on the state registers.
// Stall: while a result waits and out_ready is low, in_ready drops; in_ready
// follows out_ready combinationally when the result register is full.
// Reset: rst_n clears the request (nothing remaining) and empties the result
// register.
`include "flash_write_page_erase_splitter_assert.svh"

module flash_write_page_erase_splitter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [fwps_pkg::ADDR_W-1:0]    start_address,
    input  logic [fwps_pkg::LEN_W-1:0]     byte_length,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fwps_pkg::OP_W-1:0]      op_kind,
    output logic [fwps_pkg::ADDR_W-1:0]    flash_address,
    output logic [fwps_pkg::COUNT_W-1:0]   byte_count,
    output logic [fwps_pkg::LEN_W-1:0]     buffer_offset,
    output logic                           last
);
    import fwps_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    result_t result;
    logic    has_result;
    logic    accept;
    logic    free;

    assign in_ready = free;
    assign accept   = in_valid && in_ready;

    fwps_step u_step (
        .func          (func),
        .start_address (start_address),
        .byte_length   (byte_length),
        .state         (state_reg),
        .state_next    (state_next),
        .result        (result),
        .has_result    (has_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    fwps_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept && has_result),
        .result        (result),
        .free          (free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .op_kind       (op_kind),
        .flash_address (flash_address),
        .byte_count    (byte_count),
        .buffer_offset (buffer_offset),
        .last          (last)
    );

    `FWPS_ASSERT_IMP(a_erase_flag_aligned, state_reg.erased,
        state_reg.addr[SECTOR_W-1:0] == '0)
    `FWPS_ASSERT_IMP(a_erase_fields, out_valid && (op_kind == OP_ERASE),
        (byte_count == '0) && !last && (flash_address[SECTOR_W-1:0] == '0))
    `FWPS_ASSERT_IMP(a_program_nonempty, out_valid && (op_kind == OP_PROGRAM),
        byte_count != '0)
    `FWPS_ASSERT_NXT(a_last_drains, accept && has_result && result.last,
        state_reg.remaining == '0)
    `FWPS_ASSERT_NXT(a_advance_fills, accept && (func == FUNC_ADVANCE), out_valid)

endmodule
